FILE: design/hss_pkg.sv
package hss_pkg;

    // Item operation codes
    localparam logic [1:0] OP_EVENT  = 2'd0;
    localparam logic [1:0] OP_POLL   = 2'd1;
    localparam logic [1:0] OP_REINIT = 2'd2;
    localparam logic [1:0] OP_SPARE  = 2'd3;  // unused, behaves as a poll

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_ACTIVE_LOW = 3'd0;
    localparam logic [2:0] REG_POLES      = 3'd1;
    localparam logic [2:0] REG_GEAR       = 3'd2;
    localparam logic [2:0] REG_WHEEL      = 3'd3;
    localparam logic [2:0] REG_TIMEOUT    = 3'd4;

    localparam int unsigned ADDR_W = 5;

    // Arithmetic constants
    localparam logic [63:0] NUM_RPM = 64'd10000000;  // 60 s * 1e6 us / 6 steps
    localparam logic [25:0] K_KMH   = 26'd39321600;  // 600 * 2^16
    localparam logic [26:0] K_MMS   = 27'd128000000;
    localparam logic [24:0] PI_Q23  = 25'd26353589;  // pi, unsigned Q.23
    localparam logic [23:0] SAT24   = 24'hFFFFFF;

    // Divider job select
    typedef enum logic [1:0] {
        SEL_RPM = 2'd0,
        SEL_KMH = 2'd1,
        SEL_MMS = 2'd2
    } div_sel_t;

    typedef struct packed {
        logic        active_low;
        logic [7:0]  motor_poles;
        logic [15:0] gear_q8;
        logic [11:0] wheel_mm;
        logic [31:0] timeout_us;
    } cfg_t;

    // Controller to datapath
    typedef struct packed {
        logic     accept;
        logic     mul1;
        logic     mul2;
        logic     div_load;
        logic     div_step;
        div_sel_t sel;
        logic     load_out;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic div_last;
    } sts_t;

endpackage

FILE: design/hss_regs.sv
module hss_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hss_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output hss_pkg::cfg_t               cfg
);
    import hss_pkg::*;

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign cfg    = cfg_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.active_low  <= 1'b0;
            cfg_reg.motor_poles <= 8'd2;
            cfg_reg.gear_q8     <= 16'd256;
            cfg_reg.wheel_mm    <= 12'd500;
            cfg_reg.timeout_us  <= 32'd500000;
        end
        else if (wr_en)
        begin
            case (paddr[4:2])
                REG_ACTIVE_LOW: cfg_reg.active_low  <= pwdata[0];
                REG_POLES:      cfg_reg.motor_poles <= pwdata[7:0];
                REG_GEAR:       cfg_reg.gear_q8     <= pwdata[15:0];
                REG_WHEEL:      cfg_reg.wheel_mm    <= pwdata[11:0];
                REG_TIMEOUT:    cfg_reg.timeout_us  <= pwdata;
                default:        ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        case (paddr[4:2])
            REG_ACTIVE_LOW: prdata = {31'd0, cfg_reg.active_low};
            REG_POLES:      prdata = {24'd0, cfg_reg.motor_poles};
            REG_GEAR:       prdata = {16'd0, cfg_reg.gear_q8};
            REG_WHEEL:      prdata = {20'd0, cfg_reg.wheel_mm};
            REG_TIMEOUT:    prdata = cfg_reg.timeout_us;
            default:        prdata = 32'd0;
        endcase
    end

endmodule

FILE: design/hss_ctrl.sv
module hss_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  hss_pkg::sts_t sts,
    output hss_pkg::cmd_t cmd
);
    import hss_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MUL1 = 6'b000010,
        ST_MUL2 = 6'b000100,
        ST_LOAD = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_DONE = 6'b100000
    } state_t;

    state_t   state_reg, state_next;
    div_sel_t sel_reg, sel_next;
    logic     out_valid_reg, out_valid_next;
    logic     out_free;

    assign out_free  = ~out_valid_reg | out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        sel_next     = sel_reg;
        cmd          = '0;
        cmd.sel      = sel_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul2   = 1'b1;
                sel_next   = SEL_RPM;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    case (sel_reg)
                        SEL_RPM:
                        begin
                            sel_next   = SEL_KMH;
                            state_next = ST_LOAD;
                        end
                        SEL_KMH:
                        begin
                            sel_next   = SEL_MMS;
                            state_next = ST_LOAD;
                        end
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Output valid flag
    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sel_reg       <= SEL_RPM;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: design/hss_dp.sv
module hss_dp (
    input  logic          clk,
    input  logic          rst_n,
    input  hss_pkg::cmd_t cmd,
    output hss_pkg::sts_t sts,
    input  hss_pkg::cfg_t cfg,
    input  logic [1:0]    op,
    input  logic          level_a,
    input  logic          level_b,
    input  logic          level_c,
    input  logic [31:0]   now_us,
    output logic [2:0]    hall_mask,
    output logic          has_transition,
    output logic [31:0]   period_us,
    output logic [31:0]   last_transition_us,
    output logic [31:0]   age_us,
    output logic [23:0]   motor_rpm,
    output logic [23:0]   speed_kmh_q8,
    output logic [23:0]   speed_mm_per_s,
    output logic [31:0]   count_ok,
    output logic [31:0]   count_bad_state,
    output logic [31:0]   count_bad_jump,
    output logic [31:0]   count_events
);
    import hss_pkg::*;

    // Measurement state
    logic [2:0]  mask_reg;
    logic        valid_reg;
    logic [31:0] period_reg, last_reg;
    logic [31:0] ok_reg, bs_reg, bj_reg, ev_reg;

    // Working registers
    logic [31:0] now_reg, age_reg;
    logic        live_reg, spd_ok_reg;
    logic [38:0] pt_reg;
    logic [36:0] dpi_reg;
    logic [54:0] den_reg;
    logic [62:0] nk_reg;
    logic [63:0] nm_reg;
    logic [23:0] rpm_reg, kmh_reg, mms_reg;

    // Divider
    logic [63:0] num_reg, dvs_reg, rem_reg;
    logic [5:0]  cnt_reg;
    logic [64:0] trial, diffv;
    logic        ge;
    logic [63:0] q_next;

    // Output registers
    logic [2:0]  o_mask_reg;
    logic        o_valid_reg;
    logic [31:0] o_period_reg, o_last_reg, o_age_reg;
    logic [23:0] o_rpm_reg, o_kmh_reg, o_mms_reg;
    logic [31:0] o_ok_reg, o_bs_reg, o_bj_reg, o_ev_reg;

    logic [2:0]  cur;
    logic [2:0]  diff;
    logic        bad_state, one_step;
    logic [6:0]  pp;
    logic [38:0] pt_next;
    logic [36:0] dpi_next;
    logic [54:0] den_next;
    logic [62:0] nk_next;
    logic [63:0] nm_next;
    logic [23:0] sat_int, sat_q23;

    assign cur       = {level_c, level_b, level_a} ^ {3{cfg.active_low}};
    assign diff      = cur ^ mask_reg;
    assign bad_state = (cur == mask_reg) || (cur == 3'd0) || (cur == 3'd7);
    assign one_step  = (diff == 3'b001) || (diff == 3'b010) || (diff == 3'b100);
    assign pp        = cfg.motor_poles[7:1];

    // Classification and statistics
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg   <= 3'd0;
            valid_reg  <= 1'b0;
            period_reg <= 32'd0;
            last_reg   <= 32'd0;
            ok_reg     <= 32'd0;
            bs_reg     <= 32'd0;
            bj_reg     <= 32'd0;
            ev_reg     <= 32'd0;
        end
        else if (cmd.accept)
        begin
            case (op)
                OP_EVENT:
                begin
                    ev_reg   <= ev_reg + 32'd1;
                    mask_reg <= cur;
                    if (bad_state)
                        bs_reg <= bs_reg + 32'd1;
                    else if (!one_step)
                        bj_reg <= bj_reg + 32'd1;
                    else
                    begin
                        if (last_reg != 32'd0)
                        begin
                            period_reg <= now_us - last_reg;
                            valid_reg  <= 1'b1;
                            ok_reg     <= ok_reg + 32'd1;
                        end
                        last_reg <= now_us;
                    end
                end
                OP_REINIT:
                begin
                    mask_reg   <= cur;
                    valid_reg  <= 1'b0;
                    period_reg <= 32'd0;
                    last_reg   <= 32'd0;
                    ok_reg     <= 32'd0;
                    bs_reg     <= 32'd0;
                    bj_reg     <= 32'd0;
                    ev_reg     <= 32'd0;
                end
                default: ;
            endcase
        end
    end

    // Products: one multiply per operand path per cycle
    assign pt_next  = 39'(period_reg) * 39'(pp);
    assign dpi_next = 37'(cfg.wheel_mm) * 37'(PI_Q23);
    assign den_next = 55'(pt_reg) * 55'(cfg.gear_q8);
    assign nk_next  = 63'(dpi_reg) * 63'(K_KMH);
    assign nm_next  = 64'(dpi_reg) * 64'(K_MMS);

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            now_reg <= now_us;
        if (cmd.mul1)
        begin
            age_reg <= (last_reg != 32'd0) ? (now_reg - last_reg) : 32'd0;
            pt_reg  <= pt_next;
            dpi_reg <= dpi_next;
        end
        if (cmd.mul2)
        begin
            live_reg   <= valid_reg && (age_reg <= cfg.timeout_us) &&
                          (period_reg != 32'd0) && (pp != 7'd0);
            spd_ok_reg <= (cfg.gear_q8 != 16'd0) && (cfg.wheel_mm != 12'd0);
            den_reg    <= den_next;
            nk_reg     <= nk_next;
            nm_reg     <= nm_next;
        end
    end

    // Restoring divider, one quotient bit a cycle
    assign trial  = {rem_reg, num_reg[63]};
    assign diffv  = trial - {1'b0, dvs_reg};
    assign ge     = ~diffv[64];
    assign q_next = {num_reg[62:0], ge};
    assign sts.div_last = (cnt_reg == 6'd63);

    assign sat_int = (q_next[63:24] != 40'd0) ? SAT24 : q_next[23:0];
    assign sat_q23 = (q_next[63:47] != 17'd0) ? SAT24 : q_next[46:23];

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            rem_reg <= 64'd0;
            cnt_reg <= 6'd0;
            case (cmd.sel)
                SEL_RPM:
                begin
                    num_reg <= NUM_RPM;
                    dvs_reg <= 64'(pt_reg);
                end
                SEL_KMH:
                begin
                    num_reg <= 64'(nk_reg);
                    dvs_reg <= 64'(den_reg);
                end
                default:
                begin
                    num_reg <= nm_reg;
                    dvs_reg <= 64'(den_reg) + {8'd0, den_reg, 1'b0};
                end
            endcase
        end
        else if (cmd.div_step)
        begin
            rem_reg <= ge ? diffv[63:0] : trial[63:0];
            num_reg <= q_next;
            cnt_reg <= cnt_reg + 6'd1;
            if (sts.div_last)
            begin
                case (cmd.sel)
                    SEL_RPM: rpm_reg <= sat_int;
                    SEL_KMH: kmh_reg <= sat_q23;
                    default: mms_reg <= sat_q23;
                endcase
            end
        end
    end

    // Result snapshot
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            o_mask_reg   <= mask_reg;
            o_valid_reg  <= valid_reg;
            o_period_reg <= period_reg;
            o_last_reg   <= last_reg;
            o_age_reg    <= age_reg;
            o_rpm_reg    <= live_reg ? rpm_reg : 24'd0;
            o_kmh_reg    <= (live_reg && spd_ok_reg) ? kmh_reg : 24'd0;
            o_mms_reg    <= (live_reg && spd_ok_reg) ? mms_reg : 24'd0;
            o_ok_reg     <= ok_reg;
            o_bs_reg     <= bs_reg;
            o_bj_reg     <= bj_reg;
            o_ev_reg     <= ev_reg;
        end
    end

    assign hall_mask          = o_mask_reg;
    assign has_transition     = o_valid_reg;
    assign period_us          = o_period_reg;
    assign last_transition_us = o_last_reg;
    assign age_us             = o_age_reg;
    assign motor_rpm          = o_rpm_reg;
    assign speed_kmh_q8       = o_kmh_reg;
    assign speed_mm_per_s     = o_mms_reg;
    assign count_ok           = o_ok_reg;
    assign count_bad_state    = o_bs_reg;
    assign count_bad_jump     = o_bj_reg;
    assign count_events       = o_ev_reg;

endmodule

FILE: design/hall_sensor_speed_meter_core.sv
// Channel   Handshake               Payload
// input     in_valid / in_ready     op, level_a, level_b, level_c, now_us
// output    out_valid / out_ready   hall_mask ... count_events (snapshot)
// config    psel/penable/pwrite     paddr, pwdata, prdata, pready
//
// An item runs through accept, the multiply states MUL1 and MUL2, then three
// quotients (rpm, km/h, mm/s) on one shared 64-step restoring divider,
// each after a load state, and a final snapshot state.
// Reset is asynchronous, active low; no clearing pass is needed.
// in_ready is high only while idle; a finished snapshot waits in the
// output register, and the next item may be accepted meanwhile.
module hall_sensor_speed_meter_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  op,
    input  logic                        level_a,
    input  logic                        level_b,
    input  logic                        level_c,
    input  logic [31:0]                 now_us,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [2:0]                  hall_mask,
    output logic                        has_transition,
    output logic [31:0]                 period_us,
    output logic [31:0]                 last_transition_us,
    output logic [31:0]                 age_us,
    output logic [23:0]                 motor_rpm,
    output logic [23:0]                 speed_kmh_q8,
    output logic [23:0]                 speed_mm_per_s,
    output logic [31:0]                 count_ok,
    output logic [31:0]                 count_bad_state,
    output logic [31:0]                 count_bad_jump,
    output logic [31:0]                 count_events,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hss_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import hss_pkg::*;

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    hss_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    hss_dp u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .sts                (sts),
        .cfg                (cfg),
        .op                 (op),
        .level_a            (level_a),
        .level_b            (level_b),
        .level_c            (level_c),
        .now_us             (now_us),
        .hall_mask          (hall_mask),
        .has_transition     (has_transition),
        .period_us          (period_us),
        .last_transition_us (last_transition_us),
        .age_us             (age_us),
        .motor_rpm          (motor_rpm),
        .speed_kmh_q8       (speed_kmh_q8),
        .speed_mm_per_s     (speed_mm_per_s),
        .count_ok           (count_ok),
        .count_bad_state    (count_bad_state),
        .count_bad_jump     (count_bad_jump),
        .count_events       (count_events)
    );

endmodule

FILE: design/hss_checker.sv
module hss_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        has_transition,
    input logic [31:0] period_us,
    input logic [31:0] last_transition_us,
    input logic [31:0] age_us,
    input logic [23:0] motor_rpm,
    input logic [23:0] speed_kmh_q8,
    input logic        pready
);

    // Config port never stalls
    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

    // A pending result transfer holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(motor_rpm))
        else $error("output result dropped or changed while stalled");

    // One item at a time: busy after an input transfer
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while an item is in work");

    // No measured period means no speed and no period
    a_no_speed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_transition |->
            motor_rpm == 24'd0 && speed_kmh_q8 == 24'd0 && period_us == 32'd0)
        else $error("speed reported without a measured period");

    // Age is zero when no transition is recorded
    a_age: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_transition_us == 32'd0 |-> age_us == 32'd0)
        else $error("age without a transition timestamp");

endmodule

bind hall_sensor_speed_meter_core hss_checker u_hss_checker (.*);
